/* design/slr_pkg.sv */
// slr_pkg: shared constants and controller/datapath interface types for the
// sequenced log ring. No dependencies.
package slr_pkg;

	localparam int SEQ_W     = 64;
	localparam int DATA_W    = 32;
	localparam int RCOUNT_W  = 5;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_BATCH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_RECORD  = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	typedef struct packed {
		logic push;
		logic clear;
		logic ack;
		logic load;
		logic step;
		logic mark_more;
		logic summary;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic stop;
	} stat_t;

endpackage

/* design/slr_ram.sv */
// slr_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module slr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/slr_ctrl.sv */
// slr_ctrl: command sequencer for the sequenced log ring.
// Depends on slr_pkg.
module slr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    opcode,
	input  slr_pkg::stat_t stat,
	output slr_pkg::cmd_t  cmd,
	output logic          busy
);
	import slr_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH, ST_SUM} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (opcode)
						OP_PUSH: begin
							cmd.push = 1'b1;
						end
						OP_BATCH: begin
							cmd.load = 1'b1;
							state_d  = ST_SCAN;
						end
						OP_CLEAR: begin
							cmd.clear = 1'b1;
							cmd.ack   = 1'b1;
						end
						default: begin
							cmd.ack = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.stop) begin
					cmd.mark_more = 1'b1;
					state_d       = ST_FLUSH;
				end else if (stat.done) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FLUSH: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.summary = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != ST_IDLE);
		end
	end

endmodule

/* design/slr_datapath.sv */
// slr_datapath: ring storage, sequence/overwrite counters, batch scan and the
// result register. Depends on slr_pkg and slr_ram.
module slr_datapath #(
	parameter int DEPTH        = 64,
	parameter int BATCH_MAX    = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slr_pkg::cmd_t                cmd,
	output slr_pkg::stat_t               stat,
	input  logic [slr_pkg::DATA_W-1:0]   payload,
	input  logic [slr_pkg::SEQ_W-1:0]    read_cursor,
	output logic                         strobe,
	output logic [1:0]                   kind,
	output logic [slr_pkg::SEQ_W-1:0]    sequence_res,
	output logic [slr_pkg::DATA_W-1:0]   record_data,
	output logic [slr_pkg::SEQ_W-1:0]    new_cursor,
	output logic [slr_pkg::SEQ_W-1:0]    upcoming_sequence,
	output logic [slr_pkg::SEQ_W-1:0]    first_available,
	output logic [slr_pkg::SEQ_W-1:0]    lost_count,
	output logic [slr_pkg::SEQ_W-1:0]    overwrite_total,
	output logic                         more_pending,
	output logic [slr_pkg::RCOUNT_W-1:0] returned_count,
	output logic                         last
);
	import slr_pkg::*;

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int BCNT_W  = $clog2(BATCH_MAX + 1);
	localparam int STORE_W = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

	logic [PTR_W-1:0]  wp_q, ptr_q;
	logic [CNT_W-1:0]  fill_q, idx_q;
	logic [SEQ_W-1:0]  next_seq_q, ovw_q;
	logic [SEQ_W-1:0]  base_q, cur_in_q, cursor_q, seq_q, lost_q;
	logic [BCNT_W-1:0] bcnt_q;
	logic              more_q;
	logic              emit_s1;
	logic [SEQ_W-1:0]  seq_s1;
	logic [STORE_W-1:0] rdata;

	logic [CNT_W:0]    start_sum;
	logic [PTR_W-1:0]  start_idx;
	logic              qual;
	logic [SEQ_W:0]    lost_sum;

	slr_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (wp_q),
		.wdata (payload[STORE_W-1:0]),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	always_comb begin
		start_sum = {1'b0, CNT_W'(wp_q)} + (CNT_W + 1)'(DEPTH) - {1'b0, fill_q};
		if (start_sum >= (CNT_W + 1)'(DEPTH)) begin
			start_idx = PTR_W'(start_sum - (CNT_W + 1)'(DEPTH));
		end else begin
			start_idx = PTR_W'(start_sum);
		end
		qual      = (seq_q > cur_in_q);
		stat.done = (idx_q == fill_q);
		stat.stop = !stat.done && qual && (bcnt_q == BCNT_W'(BATCH_MAX));
		// base - cursor - 1; carry out means base > cursor
		lost_sum  = {1'b0, base_q} + {1'b0, ~cur_in_q};
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			fill_q     <= '0;
			next_seq_q <= 64'd1;
			ovw_q      <= '0;
			emit_s1    <= 1'b0;
			more_q     <= 1'b0;
			bcnt_q     <= '0;
			strobe     <= 1'b0;
		end else begin
			emit_s1 <= cmd.step && qual;
			strobe  <= emit_s1 || cmd.summary || cmd.push || cmd.ack;
			if (cmd.clear) begin
				wp_q       <= '0;
				fill_q     <= '0;
				next_seq_q <= 64'd1;
				ovw_q      <= '0;
			end else if (cmd.push) begin
				wp_q       <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
				next_seq_q <= next_seq_q + 64'd1;
				if (fill_q < CNT_W'(DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end else begin
					ovw_q <= ovw_q + 64'd1;
				end
			end
			if (cmd.load) begin
				bcnt_q <= '0;
				more_q <= 1'b0;
			end else begin
				if (cmd.step && qual) begin
					bcnt_q <= bcnt_q + 1'b1;
				end
				if (cmd.mark_more) begin
					more_q <= 1'b1;
				end
			end
		end
	end

	// scan datapath and result register
	always_ff @(posedge clk) begin
		seq_s1 <= seq_q;
		lost_q <= (fill_q != '0 && lost_sum[SEQ_W]) ? lost_sum[SEQ_W-1:0] : '0;
		if (cmd.load) begin
			base_q   <= next_seq_q - SEQ_W'(fill_q);
			seq_q    <= next_seq_q - SEQ_W'(fill_q);
			cur_in_q <= read_cursor;
			cursor_q <= read_cursor;
			ptr_q    <= start_idx;
			idx_q    <= '0;
		end else if (cmd.step) begin
			seq_q <= seq_q + 64'd1;
			ptr_q <= (ptr_q == PTR_W'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
			idx_q <= idx_q + 1'b1;
			if (qual) begin
				cursor_q <= seq_q;
			end
		end

		kind              <= KIND_ACK;
		sequence_res      <= '0;
		record_data       <= '0;
		new_cursor        <= '0;
		upcoming_sequence <= '0;
		first_available   <= '0;
		lost_count        <= '0;
		overwrite_total   <= '0;
		more_pending      <= 1'b0;
		returned_count    <= '0;
		last              <= 1'b0;
		if (emit_s1) begin
			kind         <= KIND_RECORD;
			sequence_res <= seq_s1;
			record_data  <= DATA_W'(rdata);
		end else if (cmd.summary) begin
			kind              <= KIND_SUMMARY;
			new_cursor        <= cursor_q;
			upcoming_sequence <= next_seq_q;
			first_available   <= base_q;
			lost_count        <= lost_q;
			overwrite_total   <= ovw_q;
			more_pending      <= more_q;
			returned_count    <= RCOUNT_W'(bcnt_q);
			last              <= 1'b1;
		end else if (cmd.push) begin
			sequence_res <= next_seq_q;
			last         <= 1'b1;
		end else if (cmd.ack) begin
			last <= 1'b1;
		end
	end

endmodule

/* design/sequenced_log_ring_core.sv */
// sequenced_log_ring_core: top level of the sequenced overwriting log ring.
// Depends on slr_pkg, slr_ctrl, slr_datapath (and slr_ram below it).
//
// A push, clear or unused opcode is taken while idle: its word shows on the
// result ports, marked by strobe, in the next cycle, and busy stays low, so
// one such command can be issued every cycle. A batch read raises busy from
// the cycle after acceptance: the scan visits the stored entries oldest
// first at one per cycle through the ring's single read port, stops at the
// first qualifying record beyond BATCH_MAX, then drains the read in the
// flush state and forms the summary in the sum state. Record words stream
// out while busy is high, and the summary word appears in the cycle that
// busy falls. The receiver cannot stall: every word is valid for one cycle.
module sequenced_log_ring_core #(
	parameter int DEPTH        = 64,
	parameter int BATCH_MAX    = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   opcode,
	input  logic [slr_pkg::DATA_W-1:0]   payload,
	input  logic [slr_pkg::SEQ_W-1:0]    read_cursor,
	output logic                         strobe,
	output logic [1:0]                   kind,
	output logic [slr_pkg::SEQ_W-1:0]    sequence_res,
	output logic [slr_pkg::DATA_W-1:0]   record_data,
	output logic [slr_pkg::SEQ_W-1:0]    new_cursor,
	output logic [slr_pkg::SEQ_W-1:0]    upcoming_sequence,
	output logic [slr_pkg::SEQ_W-1:0]    first_available,
	output logic [slr_pkg::SEQ_W-1:0]    lost_count,
	output logic [slr_pkg::SEQ_W-1:0]    overwrite_total,
	output logic                         more_pending,
	output logic [slr_pkg::RCOUNT_W-1:0] returned_count,
	output logic                         last
);
	import slr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	slr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	slr_datapath #(
		.DEPTH        (DEPTH),
		.BATCH_MAX    (BATCH_MAX),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.payload           (payload),
		.read_cursor       (read_cursor),
		.strobe            (strobe),
		.kind              (kind),
		.sequence_res      (sequence_res),
		.record_data       (record_data),
		.new_cursor        (new_cursor),
		.upcoming_sequence (upcoming_sequence),
		.first_available   (first_available),
		.lost_count        (lost_count),
		.overwrite_total   (overwrite_total),
		.more_pending      (more_pending),
		.returned_count    (returned_count),
		.last              (last)
	);

	a_push_ack: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == OP_PUSH |=> strobe && kind == KIND_ACK && last)
		else $error("push not acknowledged in next cycle");

	a_record_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_RECORD |-> !last && busy)
		else $error("record word marked last or outside a batch");

	a_more_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_SUMMARY && more_pending |->
		returned_count == RCOUNT_W'(BATCH_MAX))
		else $error("more_pending set on a short batch");

	a_summary_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_SUMMARY |-> !busy && $past(busy))
		else $error("summary word out of place");

endmodule
